/* hdl/rpnsc_pkg.sv */
// rpnsc_pkg: shared types, function codes and helpers for the rpn stack calculator
// no dependencies; imported by rpnsc_alu, rpnsc_stack and rpn_stack_calculator
package rpnsc_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W = $clog2(WORD_W);
	localparam int SHOWN_LEVELS = 4;

	typedef logic [WORD_W-1:0] word_t;

	// input function codes
	localparam logic [2:0] FN_PUSH = 3'd0;
	localparam logic [2:0] FN_ADD = 3'd1;
	localparam logic [2:0] FN_SUB = 3'd2;
	localparam logic [2:0] FN_MUL = 3'd3;
	localparam logic [2:0] FN_DIV = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_ZERO
	} alu_op_t;

	typedef enum logic [1:0] {
		US_IDLE,
		US_MUL,
		US_DIV,
		US_DONE
	} unit_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_WB
	} top_state_t;

	typedef struct packed {
		logic  upd;
		logic  push;
		word_t value;
	} stk_cmd_t;

	function automatic alu_op_t fn_to_op(input logic [2:0] fn);
		alu_op_t op;
		case (fn)
			FN_ADD: op = OP_ADD;
			FN_SUB: op = OP_SUB;
			FN_MUL: op = OP_MUL;
			FN_DIV: op = OP_DIV;
			default: op = OP_ZERO;
		endcase
		return op;
	endfunction

endpackage

/* hdl/rpnsc_alu.sv */
// rpnsc_alu: shared arithmetic unit, add/sub, bit-serial multiply and divide
// depends on rpnsc_pkg
module rpnsc_alu
	import rpnsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  alu_op_t op,
	input  word_t   opa,
	input  word_t   opb,
	output logic    done,
	output word_t   result
);

	unit_state_t ust_q, ust_d;
	logic [CNT_W-1:0] cnt_q;
	word_t acc_q;
	word_t a_q;
	word_t b_q;
	word_t rem_q;
	logic neg_q;

	logic [WORD_W:0] shifted;
	logic [WORD_W:0] diff;
	word_t abs_a, abs_b;

	assign abs_a = opa[WORD_W-1] ? (~opa + 1'b1) : opa;
	assign abs_b = opb[WORD_W-1] ? (~opb + 1'b1) : opb;

	// restoring divide step: bring in next dividend bit, try the subtract
	assign shifted = {rem_q, a_q[WORD_W-1]};
	assign diff = shifted - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q <= US_IDLE;
		end else begin
			ust_q <= ust_d;
		end
	end

	always_comb begin
		ust_d = ust_q;
		done = 1'b0;
		case (ust_q)
			US_IDLE: begin
				if (start) begin
					case (op)
						OP_MUL: ust_d = US_MUL;
						OP_DIV: ust_d = US_DIV;
						default: ust_d = US_DONE;
					endcase
				end
			end
			US_MUL, US_DIV: begin
				if (cnt_q == '0) ust_d = US_DONE;
			end
			US_DONE: begin
				done = 1'b1;
				ust_d = US_IDLE;
			end
			default: ust_d = US_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ust_q)
			US_IDLE: begin
				if (start) begin
					cnt_q <= CNT_W'(WORD_W - 1);
					neg_q <= 1'b0;
					a_q <= opa;
					b_q <= opb;
					rem_q <= '0;
					case (op)
						OP_ADD: acc_q <= opa + opb;
						OP_SUB: acc_q <= opa - opb;
						OP_MUL: acc_q <= '0;
						OP_DIV: begin
							acc_q <= '0;
							a_q <= abs_a;
							b_q <= abs_b;
							neg_q <= opa[WORD_W-1] ^ opb[WORD_W-1];
						end
						default: acc_q <= '0;
					endcase
				end
			end
			US_MUL: begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			US_DIV: begin
				if (!diff[WORD_W]) begin
					rem_q <= diff[WORD_W-1:0];
				end else begin
					rem_q <= shifted[WORD_W-1:0];
				end
				acc_q <= {acc_q[WORD_W-2:0], ~diff[WORD_W]};
				a_q <= a_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// quotient sign fix on the way out
	assign result = neg_q ? (~acc_q + 1'b1) : acc_q;

endmodule

/* hdl/rpnsc_stack.sv */
// rpnsc_stack: the register stack with push and pop-with-result, and next-level view
// depends on rpnsc_pkg
module rpnsc_stack
	import rpnsc_pkg::*;
#(
	parameter int STACK_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  stk_cmd_t cmd,
	output word_t    lvl_x,
	output word_t    lvl_y,
	output logic [SHOWN_LEVELS-1:0][WORD_W-1:0] shown_nxt
);

	word_t levels_q [STACK_DEPTH];
	word_t levels_d [STACK_DEPTH];

	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			levels_d[i] = levels_q[i];
		end
		if (cmd.upd) begin
			levels_d[0] = cmd.value;
			if (cmd.push) begin
				for (int i = 1; i < STACK_DEPTH; i++) begin
					levels_d[i] = levels_q[i-1];
				end
			end else begin
				for (int i = 1; i < STACK_DEPTH - 1; i++) begin
					levels_d[i] = levels_q[i+1];
				end
				levels_d[STACK_DEPTH-1] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				levels_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				levels_q[i] <= levels_d[i];
			end
		end
	end

	assign lvl_x = levels_q[0];
	assign lvl_y = levels_q[1];

	// levels missing from a shallow stack read as zero
	for (genvar g = 0; g < SHOWN_LEVELS; g++) begin : g_shown
		if (g < STACK_DEPTH) begin : g_real
			assign shown_nxt[g] = levels_d[g];
		end else begin : g_none
			assign shown_nxt[g] = '0;
		end
	end

endmodule

/* hdl/rpn_stack_calculator.sv */
// rpn_stack_calculator: four-level rpn calculator, sequencer around a shared bit-serial alu
// path, accept to out_valid: push or refused divide goes straight to write-back; add, sub,
// other, mul, div wait on the alu first (mul, div: 32 iterations, one quotient or product bit per cycle)
// throughput: one item at a time; in_ready is low from accept until the result is registered
// the output register lets the next item start while a result waits for out_ready
// reset (arst_n, async) clears the stack, the sequencer and out_valid
module rpn_stack_calculator
	import rpnsc_pkg::*;
#(
	parameter int STACK_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_reg,
	output logic signed [31:0] y_reg,
	output logic signed [31:0] z_reg,
	output logic signed [31:0] t_reg,
	output logic               div_zero_error
);

	top_state_t state_q, state_d;
	logic [2:0] func_q;
	word_t val_q;
	logic err_q;
	logic out_valid_q;
	word_t x_q, y_q, z_q, t_q;
	logic err_out_q;

	logic accept;
	logic wb_fire;
	logic x_zero_div;
	logic need_unit;
	logic u_start;
	logic u_done;
	word_t u_result;
	word_t stk_x, stk_y;
	stk_cmd_t stk_cmd;
	logic [SHOWN_LEVELS-1:0][WORD_W-1:0] shown_nxt;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid & in_ready;
	assign x_zero_div = (func == FN_DIV) && (stk_x == '0);
	assign need_unit = (func != FN_PUSH) && !x_zero_div;
	assign u_start = accept & need_unit;
	assign wb_fire = (state_q == ST_WB) && (!out_valid_q || out_ready);

	rpnsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.op     (fn_to_op(func)),
		.opa    (stk_y),
		.opb    (stk_x),
		.done   (u_done),
		.result (u_result)
	);

	always_comb begin
		stk_cmd.upd = wb_fire & ~err_q;
		stk_cmd.push = (func_q == FN_PUSH);
		stk_cmd.value = val_q;
	end

	rpnsc_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.lvl_x     (stk_x),
		.lvl_y     (stk_y),
		.shown_nxt (shown_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = need_unit ? ST_WAIT : ST_WB;
			end
			ST_WAIT: begin
				if (u_done) state_d = ST_WB;
			end
			ST_WB: begin
				if (wb_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			val_q <= word_t'(push_value);
			err_q <= x_zero_div;
		end else if (u_done) begin
			val_q <= u_result;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			x_q <= shown_nxt[0];
			y_q <= shown_nxt[1];
			z_q <= shown_nxt[2];
			t_q <= shown_nxt[3];
			err_out_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign x_reg = $signed(x_q);
	assign y_reg = $signed(y_q);
	assign z_reg = $signed(z_q);
	assign t_reg = $signed(t_q);
	assign div_zero_error = err_out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == ST_WAIT))
		else $error("alu done outside of wait state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready high right after an accepted beat");

	a_err_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_fire && err_q) |-> (func_q == FN_DIV))
		else $error("divide error flagged on a non-divide item");

	a_unit_idle_on_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) && u_done |=> (state_q == ST_WB))
		else $error("result from alu not written back");

endmodule

/* verif/tb_rpn_stack_calculator.sv */
`timescale 1ns / 100ps
// tb_rpn_stack_calculator: self-checking bench for the four-level rpn calculator stack
// depends on rpnsc_pkg and rpn_stack_calculator; an in-bench stack model predicts each beat
module tb_rpn_stack_calculator;
	import rpnsc_pkg::*;

	localparam int DEPTH = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_KEYS = 550;

	// operator codes past divide: all give zero and pop
	localparam logic [2:0] FN_OTHER = 3'd5;
	localparam logic [2:0] FN_SPARE_6 = 3'd6;
	localparam logic [2:0] FN_SPARE_7 = 3'd7;

	localparam word_t INT_MAX = 32'h7fff_ffff;
	localparam word_t INT_MIN = 32'h8000_0000;
	localparam word_t MINUS_ONE = 32'hffff_ffff;

	typedef struct packed {
		logic [2:0] fn;
		word_t      val;
	} key_item_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t t;
		logic  err;
	} stack_view_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] func = '0;
	logic signed [31:0] push_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] x_reg;
	logic signed [31:0] y_reg;
	logic signed [31:0] z_reg;
	logic signed [31:0] t_reg;
	logic div_zero_error;

	key_item_t pending_keys[$];
	stack_view_t expected_views[$];
	word_t model_levels[DEPTH] = '{default: '0};

	int mismatch_count = 0;
	int beats_seen = 0;
	int keys_accepted = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int hold_at = 150;
	int tx_gap = 0;
	int tx_run = 0;
	int rx_stall = 0;
	int rx_run = 0;

	rpn_stack_calculator #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_reg(x_reg),
		.y_reg(y_reg),
		.z_reg(z_reg),
		.t_reg(t_reg),
		.div_zero_error(div_zero_error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR beat %0d: %s", beats_seen, msg);
		mismatch_count++;
	endtask

	// mostly short gaps, a few long ones, and runs with no gap at all
	function automatic int pick_gap(inout int run_left);
		int r;
		r = $urandom_range(0, 99);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if (r < 5) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5: return word_t'($signed($urandom_range(0, 40)) - 20);
			6: return '0;
			7: return INT_MIN;
			8: return INT_MAX;
			default: return MINUS_ONE;
		endcase
	endfunction

	function automatic logic [2:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 44) return FN_PUSH;
		if (r < 54) return FN_ADD;
		if (r < 64) return FN_SUB;
		if (r < 76) return FN_MUL;
		if (r < 90) return FN_DIV;
		if (r < 96) return FN_OTHER;
		if (r < 98) return FN_SPARE_6;
		return FN_SPARE_7;
	endfunction

	task automatic queue_key(input logic [2:0] fn, input word_t val);
		key_item_t k;
		k.fn = fn;
		k.val = val;
		pending_keys.push_back(k);
	endtask

	// apply one accepted key to the stack model and record the view it should produce
	task automatic advance_stack(input logic [2:0] fn, input word_t val);
		word_t x;
		word_t y;
		word_t res;
		word_t ax;
		word_t ay;
		word_t q;
		logic err;
		logic pops;
		stack_view_t v;
		word_t shown[SHOWN_LEVELS];
		int i;
		x = model_levels[0];
		y = model_levels[1];
		res = '0;
		err = 1'b0;
		pops = 1'b1;
		case (fn)
			FN_PUSH: begin
				pops = 1'b0;
				for (i = DEPTH - 1; i > 0; i--) model_levels[i] = model_levels[i-1];
				model_levels[0] = val;
			end
			FN_ADD: res = y + x;
			FN_SUB: res = y - x;
			FN_MUL: res = y * x;
			FN_DIV: begin
				if (x == '0) begin
					err = 1'b1;
					pops = 1'b0;
				end else begin
					// divide magnitudes, then fix the sign: truncates toward zero
					ay = y[31] ? -y : y;
					ax = x[31] ? -x : x;
					q = ay / ax;
					res = (y[31] ^ x[31]) ? -q : q;
				end
			end
			default: res = '0;
		endcase
		if (pops) begin
			model_levels[0] = res;
			for (i = 1; i < DEPTH - 1; i++) model_levels[i] = model_levels[i+1];
			model_levels[DEPTH-1] = '0;
		end
		for (i = 0; i < SHOWN_LEVELS; i++) shown[i] = (i < DEPTH) ? model_levels[i] : '0;
		v.x = shown[0];
		v.y = shown[1];
		v.z = shown[2];
		v.t = shown[3];
		v.err = err;
		expected_views.push_back(v);
	endtask

	task automatic check_beat();
		stack_view_t want;
		if (expected_views.size() == 0) begin
			report_mismatch("result beat with nothing expected");
			return;
		end
		want = expected_views.pop_front();
		if (word_t'(x_reg) !== want.x)
			report_mismatch($sformatf("x_reg got %h want %h", x_reg, want.x));
		if (word_t'(y_reg) !== want.y)
			report_mismatch($sformatf("y_reg got %h want %h", y_reg, want.y));
		if (word_t'(z_reg) !== want.z)
			report_mismatch($sformatf("z_reg got %h want %h", z_reg, want.z));
		if (word_t'(t_reg) !== want.t)
			report_mismatch($sformatf("t_reg got %h want %h", t_reg, want.t));
		if (div_zero_error !== want.err)
			report_mismatch($sformatf("div_zero_error got %b want %b", div_zero_error, want.err));
	endtask

	// driver: offers the next pending key once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		key_item_t k;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= '0;
			push_value <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid && in_ready) begin
				advance_stack(func, push_value);
				keys_accepted <= keys_accepted + 1;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pending_keys.size() != 0) begin
				k = pending_keys.pop_front();
				in_valid <= 1'b1;
				func <= k.fn;
				push_value <= k.val;
				tx_gap = pick_gap(tx_run);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-offs so the result register fills and input stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (keys_accepted >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_at <= hold_at + 270;
		end
	end

	// monitor: checks each result beat and throttles out_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_beat();
				beats_seen++;
				rx_stall = pick_gap(rx_run);
			end
			out_ready <= (rx_stall == 0) && (hold_left == 0);
			if (rx_stall > 0) rx_stall--;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("rpn_stack_calculator regression: fail");
			$finish;
		end
	end

	initial begin
		int n;
		// wraps, min over minus one, refused divide, truncation, every operator, t dropped
		queue_key(FN_PUSH, INT_MAX);
		queue_key(FN_PUSH, 32'd1);
		queue_key(FN_ADD, $urandom);
		queue_key(FN_PUSH, INT_MIN);
		queue_key(FN_PUSH, MINUS_ONE);
		queue_key(FN_DIV, $urandom);
		queue_key(FN_PUSH, '0);
		queue_key(FN_DIV, $urandom);
		queue_key(FN_PUSH, -32'sd7);
		queue_key(FN_PUSH, 32'd2);
		queue_key(FN_DIV, $urandom);
		queue_key(FN_SUB, $urandom);
		queue_key(FN_PUSH, 32'h0001_0000);
		queue_key(FN_PUSH, 32'h0001_0001);
		queue_key(FN_MUL, $urandom);
		queue_key(FN_PUSH, MINUS_ONE);
		queue_key(FN_MUL, $urandom);
		queue_key(FN_OTHER, $urandom);
		queue_key(FN_SPARE_6, $urandom);
		queue_key(FN_PUSH, 32'd5);
		queue_key(FN_SPARE_7, $urandom);
		queue_key(FN_PUSH, 32'h5555_5555);
		queue_key(FN_PUSH, 32'haaaa_aaaa);
		queue_key(FN_PUSH, 32'd3);
		queue_key(FN_PUSH, 32'd4);
		for (n = 0; n < RANDOM_KEYS; n++) begin
			queue_key(pick_func(), pick_operand());
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_keys.size() != 0 || in_valid || expected_views.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);

		if (mismatch_count == 0 && expected_views.size() == 0) begin
			$display("rpn_stack_calculator regression: pass");
		end else begin
			$display("rpn_stack_calculator regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/rpnsc_pkg.sv
hdl/rpnsc_alu.sv
hdl/rpnsc_stack.sv
hdl/rpn_stack_calculator.sv
verif/tb_rpn_stack_calculator.sv
